// File: rtl/binary64_add_sub_mul_div_assert.svh
// Assertion macros used by the checker of the binary64 arithmetic unit.
// No dependencies; included by the checker.
`ifndef BINARY64_ADD_SUB_MUL_DIV_ASSERT_SVH
`define BINARY64_ADD_SUB_MUL_DIV_ASSERT_SVH

// concurrent assertion, disabled while reset is asserted
`define B64_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion that is also checked during reset
`define B64_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/b64asmd_pkg.sv
// Shared constants, operation codes and helper functions for the binary64 unit.
// No dependencies.
`timescale 1ns / 1ps

package b64asmd_pkg;

    localparam int FRAC_W    = 52;
    localparam int EXP_W     = 11;
    localparam int MANT_W    = FRAC_W + 1;
    localparam int GRD_W     = MANT_W + 3;
    localparam int SEXP_W    = 14;
    localparam int EXP_BIAS  = 1023;
    localparam int EXP_MAX   = 2047;
    localparam int DIV_STEPS = GRD_W;

    localparam logic [63:0] QNAN_BITS = 64'h7ff8_0000_0000_0000;
    localparam logic [63:0] INF_BITS  = 64'h7ff0_0000_0000_0000;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    // leading zero count of a guarded significand (zero input gives 0)
    function automatic logic [5:0] lzc_f(input logic [GRD_W-1:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < GRD_W; i++) begin
            if (v[i]) begin
                n = 6'(GRD_W - 1 - i);
            end
        end
        return n;
    endfunction

    // right shift, every bit shifted out is ORed into bit 0
    function automatic logic [GRD_W-1:0] shr_jam_f(input logic [GRD_W-1:0] v,
                                                  input logic [5:0] n);
        logic [GRD_W-1:0] sh;
        logic [GRD_W-1:0] mask;
        sh   = v >> n;
        mask = ~({GRD_W{1'b1}} << n);
        return {sh[GRD_W-1:1], sh[0] | (|(v & mask))};
    endfunction

endpackage

// File: rtl/binary64_add_sub_mul_div.sv
// Throughput: one transfer per cycle while the skid entry is empty (s_tready high);
// the quotient path sets the depth, one quotient bit per stage over 56 stages,
// and every kind flows through all stages.
// A two-entry output register/skid lets input continue while a result waits.
// Reset (aresetn low, synchronous) empties the pipeline and the output stage.
// Fully pipelined binary64 add/sub/mul/div, round to nearest even.
// Depends on b64asmd_pkg.
`timescale 1ns / 1ps

module binary64_add_sub_mul_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // operand_a [63:0], operand_b [127:64]
    input  logic [1:0]   s_tuser,   // kind [1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // result [63:0]
);
    import b64asmd_pkg::*;

    localparam int NSTAGE = 4 + DIV_STEPS + 1 + 5;

    typedef logic signed [SEXP_W-1:0] sexp_t;

    typedef struct packed {
        kind_t             kind;
        logic              spec;
        logic [63:0]       spec_val;
        logic              sa;
        logic              sb;
        logic [EXP_W-1:0]  ea;
        logic [EXP_W-1:0]  eb;
        logic [MANT_W-1:0] ma;
        logic [MANT_W-1:0] mb;
        logic              swap;
        logic [5:0]        lza;
        logic [5:0]        lzb;
    } s1_t;

    typedef struct packed {
        kind_t             kind;
        logic              spec;
        logic [63:0]       spec_val;
        logic              sgn;
        logic              add_sub;
        logic [EXP_W-1:0]  add_e;
        logic [EXP_W-1:0]  add_d;
        logic [MANT_W-1:0] add_mx;
        logic [MANT_W-1:0] add_my;
        sexp_t             ea;
        sexp_t             eb;
        logic [MANT_W-1:0] ma;
        logic [MANT_W-1:0] mb;
    } s2_t;

    typedef struct packed {
        kind_t             kind;
        logic              spec;
        logic [63:0]       spec_val;
        logic              sgn;
        logic              add_sub;
        logic [GRD_W-1:0]  add_mx;
        logic [GRD_W-1:0]  add_my;
        sexp_t             e;
        logic [53:0]       p_ll;
        logic [52:0]       p_lh;
        logic [52:0]       p_hl;
        logic [51:0]       p_hh;
        logic [MANT_W:0]   rem;
        logic [MANT_W-1:0] dvs;
    } s3_t;

    typedef struct packed {
        kind_t             kind;
        logic              spec;
        logic [63:0]       spec_val;
        logic              sgn;
        sexp_t             e;
        logic [GRD_W:0]    acc;
        logic [105:0]      prod;
        logic [MANT_W:0]   rem;
        logic [MANT_W-1:0] dvs;
    } s4_t;

    typedef struct packed {
        logic              spec;
        logic [63:0]       spec_val;
        logic              sgn;
        sexp_t             e;
        logic              is_div;
        logic [GRD_W-1:0]  mant;
        logic [MANT_W:0]   rem;
        logic [MANT_W-1:0] dvs;
    } wk_t;

    typedef struct packed {
        logic             spec;
        logic [63:0]      spec_val;
        logic             sgn;
        sexp_t            e;
        logic [GRD_W-1:0] mant;
        logic [5:0]       lz;
    } rn_t;

    typedef struct packed {
        logic             spec;
        logic [63:0]      spec_val;
        logic             sgn;
        sexp_t            e;
        logic [GRD_W-1:0] mant;
    } nm_t;

    typedef struct packed {
        logic          spec;
        logic [63:0]   spec_val;
        logic          sgn;
        sexp_t         e;
        logic [MANT_W:0] r;
    } rd_t;

    logic              en;
    logic [NSTAGE-1:0] vld_reg;

    s1_t st1_reg, st1_next;
    s2_t st2_reg, st2_next;
    s3_t st3_reg, st3_next;
    s4_t st4_reg, st4_next;
    wk_t wk_reg  [0:DIV_STEPS];
    wk_t wk_next [0:DIV_STEPS];
    rn_t n1_reg, n1_next;
    nm_t n2_reg, n2_next;
    nm_t r1_reg, r1_next;
    rd_t r2_reg, r2_next;
    logic [63:0] fin_reg, fin_next;

    logic        out_v_reg, sk_v_reg;
    logic [63:0] out_d_reg, sk_d_reg;

    // stage 1 decode signals
    kind_t       in_kind;
    logic [63:0] in_a, in_b;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, x_sgn;
    logic [10:0] fa, fb;

    assign en       = !sk_v_reg;
    assign s_tready = en;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

    // ---------------- stage 1: classify, special results, split
    always_comb begin
        in_kind = kind_t'(s_tuser);
        in_a    = s_tdata[63:0];
        in_b    = s_tdata[127:64] ^ {in_kind == KIND_SUB, 63'd0};
        a_nan   = in_a[62:0] > INF_BITS[62:0];
        b_nan   = in_b[62:0] > INF_BITS[62:0];
        a_inf   = in_a[62:0] == INF_BITS[62:0];
        b_inf   = in_b[62:0] == INF_BITS[62:0];
        a_zero  = in_a[62:0] == 63'd0;
        b_zero  = in_b[62:0] == 63'd0;
        x_sgn   = in_a[63] ^ in_b[63];
        fa      = in_a[62:52];
        fb      = in_b[62:52];

        st1_next.kind     = in_kind;
        st1_next.spec     = 1'b1;
        st1_next.spec_val = QNAN_BITS;
        st1_next.sa       = in_a[63];
        st1_next.sb       = in_b[63];
        st1_next.ea       = (fa == '0) ? 11'd1 : fa;
        st1_next.eb       = (fb == '0) ? 11'd1 : fb;
        st1_next.ma       = {fa != '0, in_a[51:0]};
        st1_next.mb       = {fb != '0, in_b[51:0]};
        st1_next.swap     = in_b[62:0] > in_a[62:0];
        st1_next.lza      = lzc_f({fa != '0, in_a[51:0], 3'b000});
        st1_next.lzb      = lzc_f({fb != '0, in_b[51:0], 3'b000});

        case (in_kind) inside
            KIND_ADD, KIND_SUB: begin
                if (a_nan || b_nan) begin
                    st1_next.spec_val = QNAN_BITS;
                end else if (a_inf && b_inf) begin
                    st1_next.spec_val = (in_a[63] != in_b[63]) ? QNAN_BITS : in_a;
                end else if (a_inf) begin
                    st1_next.spec_val = in_a;
                end else if (b_inf) begin
                    st1_next.spec_val = in_b;
                end else if (a_zero && b_zero) begin
                    st1_next.spec_val = in_a & in_b;
                end else if (a_zero) begin
                    st1_next.spec_val = in_b;
                end else if (b_zero) begin
                    st1_next.spec_val = in_a;
                end else begin
                    st1_next.spec = 1'b0;
                end
            end
            KIND_MUL: begin
                if (a_nan || b_nan) begin
                    st1_next.spec_val = QNAN_BITS;
                end else if (a_inf || b_inf) begin
                    st1_next.spec_val = (a_zero || b_zero) ? QNAN_BITS
                                                           : {x_sgn, INF_BITS[62:0]};
                end else if (a_zero || b_zero) begin
                    st1_next.spec_val = {x_sgn, 63'd0};
                end else begin
                    st1_next.spec = 1'b0;
                end
            end
            default: begin
                if (a_nan || b_nan) begin
                    st1_next.spec_val = QNAN_BITS;
                end else if (a_inf) begin
                    st1_next.spec_val = b_inf ? QNAN_BITS : {x_sgn, INF_BITS[62:0]};
                end else if (b_inf) begin
                    st1_next.spec_val = {x_sgn, 63'd0};
                end else if (b_zero) begin
                    st1_next.spec_val = a_zero ? QNAN_BITS : {x_sgn, INF_BITS[62:0]};
                end else if (a_zero) begin
                    st1_next.spec_val = {x_sgn, 63'd0};
                end else begin
                    st1_next.spec = 1'b0;
                end
            end
        endcase
    end

    // ---------------- stage 2: order addends, normalize mul/div operands
    always_comb begin
        st2_next.kind     = st1_reg.kind;
        st2_next.spec     = st1_reg.spec;
        st2_next.spec_val = st1_reg.spec_val;
        st2_next.add_sub  = st1_reg.sa ^ st1_reg.sb;
        if (st1_reg.swap) begin
            st2_next.add_e  = st1_reg.eb;
            st2_next.add_d  = st1_reg.eb - st1_reg.ea;
            st2_next.add_mx = st1_reg.mb;
            st2_next.add_my = st1_reg.ma;
        end else begin
            st2_next.add_e  = st1_reg.ea;
            st2_next.add_d  = st1_reg.ea - st1_reg.eb;
            st2_next.add_mx = st1_reg.ma;
            st2_next.add_my = st1_reg.mb;
        end
        if (st1_reg.kind == KIND_ADD || st1_reg.kind == KIND_SUB) begin
            st2_next.sgn = st1_reg.swap ? st1_reg.sb : st1_reg.sa;
        end else begin
            st2_next.sgn = st1_reg.sa ^ st1_reg.sb;
        end
        st2_next.ea = $signed({3'b000, st1_reg.ea}) - $signed({8'd0, st1_reg.lza});
        st2_next.eb = $signed({3'b000, st1_reg.eb}) - $signed({8'd0, st1_reg.lzb});
        st2_next.ma = st1_reg.ma << st1_reg.lza;
        st2_next.mb = st1_reg.mb << st1_reg.lzb;
    end

    // ---------------- stage 3: align, partial products, divider setup
    always_comb begin
        st3_next.kind     = st2_reg.kind;
        st3_next.spec     = st2_reg.spec;
        st3_next.spec_val = st2_reg.spec_val;
        st3_next.sgn      = st2_reg.sgn;
        st3_next.add_sub  = st2_reg.add_sub;
        st3_next.add_mx   = {st2_reg.add_mx, 3'b000};
        st3_next.add_my   = shr_jam_f({st2_reg.add_my, 3'b000},
                                      (st2_reg.add_d > 11'd63) ? 6'd63 : st2_reg.add_d[5:0]);
        st3_next.p_ll = 54'(st2_reg.ma[26:0])  * 54'(st2_reg.mb[26:0]);
        st3_next.p_lh = 53'(st2_reg.ma[26:0])  * 53'(st2_reg.mb[52:27]);
        st3_next.p_hl = 53'(st2_reg.ma[52:27]) * 53'(st2_reg.mb[26:0]);
        st3_next.p_hh = 52'(st2_reg.ma[52:27]) * 52'(st2_reg.mb[52:27]);
        st3_next.dvs  = st2_reg.mb;
        // dividend doubled when smaller than divisor, so the first quotient bit is 1
        if (st2_reg.ma < st2_reg.mb) begin
            st3_next.rem = {st2_reg.ma, 1'b0};
        end else begin
            st3_next.rem = {1'b0, st2_reg.ma};
        end
        case (st2_reg.kind) inside
            KIND_ADD, KIND_SUB: begin
                st3_next.e = $signed({3'b000, st2_reg.add_e});
            end
            KIND_MUL: begin
                st3_next.e = st2_reg.ea + st2_reg.eb - sexp_t'(EXP_BIAS);
            end
            default: begin
                st3_next.e = st2_reg.ea - st2_reg.eb + sexp_t'(EXP_BIAS)
                             - ((st2_reg.ma < st2_reg.mb) ? sexp_t'(1) : sexp_t'(0));
            end
        endcase
    end

    // ---------------- stage 4: significand add/sub, product sum
    always_comb begin
        st4_next.kind     = st3_reg.kind;
        st4_next.spec     = st3_reg.spec;
        st4_next.spec_val = st3_reg.spec_val;
        st4_next.sgn      = st3_reg.sgn;
        st4_next.e        = st3_reg.e;
        st4_next.rem      = st3_reg.rem;
        st4_next.dvs      = st3_reg.dvs;
        if (st3_reg.add_sub) begin
            st4_next.acc = {1'b0, st3_reg.add_mx} - {1'b0, st3_reg.add_my};
        end else begin
            st4_next.acc = {1'b0, st3_reg.add_mx} + {1'b0, st3_reg.add_my};
        end
        st4_next.prod = (106'(st3_reg.p_hh) << 54)
                      + ((106'(st3_reg.p_lh) + 106'(st3_reg.p_hl)) << 27)
                      + 106'(st3_reg.p_ll);
        // exact cancellation gives +0
        if ((st3_reg.kind == KIND_ADD || st3_reg.kind == KIND_SUB) && !st3_reg.spec
            && st3_reg.add_sub && st3_reg.add_mx == st3_reg.add_my) begin
            st4_next.spec     = 1'b1;
            st4_next.spec_val = 64'd0;
        end
    end

    // ---------------- stage 5: common guarded significand
    always_comb begin
        wk_next[0].spec     = st4_reg.spec;
        wk_next[0].spec_val = st4_reg.spec_val;
        wk_next[0].sgn      = st4_reg.sgn;
        wk_next[0].e        = st4_reg.e;
        wk_next[0].is_div   = 1'b0;
        wk_next[0].mant     = st4_reg.acc[GRD_W-1:0];
        wk_next[0].rem      = st4_reg.rem;
        wk_next[0].dvs      = st4_reg.dvs;
        case (st4_reg.kind) inside
            KIND_ADD, KIND_SUB: begin
                if (st4_reg.acc[GRD_W]) begin
                    wk_next[0].mant = {st4_reg.acc[GRD_W:2], |st4_reg.acc[1:0]};
                    wk_next[0].e    = st4_reg.e + sexp_t'(1);
                end
            end
            KIND_MUL: begin
                if (st4_reg.prod[105]) begin
                    wk_next[0].mant = {st4_reg.prod[105:51], |st4_reg.prod[50:0]};
                    wk_next[0].e    = st4_reg.e + sexp_t'(1);
                end else begin
                    wk_next[0].mant = {st4_reg.prod[104:50], |st4_reg.prod[49:0]};
                end
            end
            default: begin
                wk_next[0].is_div = 1'b1;
                wk_next[0].mant   = '0;
            end
        endcase
    end

    // ---------------- quotient pipeline: one restoring step per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic              ge;
        logic [MANT_W-1:0] dif;
        always_comb begin
            wk_next[k+1] = wk_reg[k];
            ge  = wk_reg[k].rem >= {1'b0, wk_reg[k].dvs};
            dif = ge ? MANT_W'(wk_reg[k].rem - {1'b0, wk_reg[k].dvs})
                     : wk_reg[k].rem[MANT_W-1:0];
            if (wk_reg[k].is_div) begin
                wk_next[k+1].rem  = {dif, 1'b0};
                wk_next[k+1].mant = {wk_reg[k].mant[GRD_W-2:0], ge};
                if (k == DIV_STEPS - 1) begin
                    wk_next[k+1].mant[0] = ge | (dif != '0);
                end
            end
        end
    end

    // ---------------- normalize: count, then shift
    always_comb begin
        n1_next.spec     = wk_reg[DIV_STEPS].spec;
        n1_next.spec_val = wk_reg[DIV_STEPS].spec_val;
        n1_next.sgn      = wk_reg[DIV_STEPS].sgn;
        n1_next.e        = wk_reg[DIV_STEPS].e;
        n1_next.mant     = wk_reg[DIV_STEPS].mant;
        n1_next.lz       = lzc_f(wk_reg[DIV_STEPS].mant);
    end

    always_comb begin
        n2_next.spec     = n1_reg.spec;
        n2_next.spec_val = n1_reg.spec_val;
        n2_next.sgn      = n1_reg.sgn;
        n2_next.mant     = n1_reg.mant << n1_reg.lz;
        n2_next.e        = n1_reg.e - $signed({8'd0, n1_reg.lz});
    end

    // ---------------- denormalize for tiny results
    sexp_t r1_sh;
    always_comb begin
        r1_next = n2_reg;
        r1_sh   = sexp_t'(1) - n2_reg.e;
        if (n2_reg.e <= sexp_t'(0)) begin
            r1_next.mant = shr_jam_f(n2_reg.mant,
                                     (r1_sh > sexp_t'(63)) ? 6'd63 : r1_sh[5:0]);
            r1_next.e    = '0;
        end
    end

    // ---------------- round to nearest even
    logic [2:0] r2_low;
    logic       r2_inc;
    always_comb begin
        r2_low           = r1_reg.mant[2:0];
        r2_inc           = (r2_low > 3'd4) || (r2_low == 3'd4 && r1_reg.mant[3]);
        r2_next.spec     = r1_reg.spec;
        r2_next.spec_val = r1_reg.spec_val;
        r2_next.sgn      = r1_reg.sgn;
        r2_next.e        = r1_reg.e;
        r2_next.r        = {1'b0, r1_reg.mant[GRD_W-1:3]} + {{MANT_W{1'b0}}, r2_inc};
    end

    // ---------------- pack
    logic [MANT_W-1:0] pk_r;
    sexp_t             pk_e;
    always_comb begin
        if (r2_reg.r[MANT_W]) begin
            pk_r = r2_reg.r[MANT_W:1];
            pk_e = r2_reg.e + sexp_t'(1);
        end else begin
            pk_r = r2_reg.r[MANT_W-1:0];
            pk_e = r2_reg.e;
        end
        if (r2_reg.spec) begin
            fin_next = r2_reg.spec_val;
        end else if (pk_e >= sexp_t'(EXP_MAX)) begin
            fin_next = {r2_reg.sgn, INF_BITS[62:0]};
        end else if (pk_r[FRAC_W]) begin
            fin_next = {r2_reg.sgn, (pk_e <= sexp_t'(0)) ? 11'd1 : pk_e[EXP_W-1:0],
                        pk_r[FRAC_W-1:0]};
        end else begin
            fin_next = {r2_reg.sgn, 11'd0, pk_r[FRAC_W-1:0]};
        end
    end

    // ---------------- pipeline registers
    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            for (int i = 0; i <= DIV_STEPS; i++) begin
                wk_reg[i] <= wk_next[i];
            end
            n1_reg  <= n1_next;
            n2_reg  <= n2_next;
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
            fin_reg <= fin_next;
        end
    end

    // ---------------- valids and output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[NSTAGE-2:0], s_tvalid};
            end
            if (sk_v_reg) begin
                if (m_tready) begin
                    sk_v_reg <= 1'b0;
                end
            end else if (vld_reg[NSTAGE-1]) begin
                if (!out_v_reg || m_tready) begin
                    out_v_reg <= 1'b1;
                end else begin
                    sk_v_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sk_v_reg) begin
            if (m_tready) begin
                out_d_reg <= sk_d_reg;
            end
        end else if (vld_reg[NSTAGE-1]) begin
            if (!out_v_reg || m_tready) begin
                out_d_reg <= fin_reg;
            end else begin
                sk_d_reg <= fin_reg;
            end
        end
    end

endmodule

// File: rtl/b64asmd_chk.sv
// Port-level checker for the binary64 arithmetic unit, bound to the top level.
// Depends on binary64_add_sub_mul_div_assert.svh.
`timescale 1ns / 1ps
`include "binary64_add_sub_mul_div_assert.svh"

module b64asmd_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

`B64_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
`B64_ASSERT_NR(a_rst_empty, aclk, !aresetn |=> !m_tvalid && s_tready, "not empty after reset")
`B64_ASSERT(a_stall_cause, aclk, aresetn, $fell(s_tready) |-> $past(m_tvalid && !m_tready), "input stalled without output backpressure")
`B64_ASSERT(a_skid_full, aclk, aresetn, !s_tready |-> m_tvalid, "input stalled with empty output")

endmodule

bind binary64_add_sub_mul_div b64asmd_chk u_b64asmd_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
